@@ sv/isl_pkg.sv @@
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants of the idle session tracker
// Command and result words, operation and state codes, register defaults.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int DEF_SESSION_SLOTS = 64;
  localparam int SLOT_W            = 6;
  localparam int TIME_W            = 32;
  localparam int TIMEOUT_W         = 16;
  localparam int MARGIN_W          = 8;
  localparam int CFG_DATA_W        = 16;
  localparam int Q_DEPTH           = 2;

  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_TOUCH = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  localparam logic CFG_IDLE_TIMEOUT  = 1'b0;
  localparam logic CFG_EXPIRY_MARGIN = 1'b1;

  localparam logic [TIMEOUT_W-1:0] RESET_IDLE_TIMEOUT  = 16'd300;
  localparam logic [MARGIN_W-1:0]  RESET_EXPIRY_MARGIN = 8'd1;

  typedef enum logic [1:0] {
    OP_OPEN,
    OP_TOUCH,
    OP_CHECK,
    OP_REPLY
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
    logic              status;
  } cmd_t;

  typedef struct packed {
    logic                 status;
    logic                 evicted_valid;
    logic [SLOT_W-1:0]    evicted_slot;
    logic                 wait_valid;
    logic [TIMEOUT_W-1:0] wait_sec;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UL_WR,
    ST_LK_SELF,
    ST_LK_HEAD,
    ST_REPLY,
    ST_CK_RD,
    ST_CK_AGE,
    ST_CK_EVAL
  } st_t;

endpackage

@@ sv/isl_ram.sv @@
// ----------------------------------------------------------------------------
// isl_ram: generic single write, single read memory
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module isl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/isl_front.sv @@
// ----------------------------------------------------------------------------
// isl_front: input classification
// Turns an input word into a command and pushes it while the queue has room.
// ----------------------------------------------------------------------------
module isl_front import isl_pkg::*; #(
  parameter int SESSION_SLOTS = DEF_SESSION_SLOTS
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [SLOT_W-1:0] slot,
  input  logic [TIME_W-1:0] now_sec,
  input  q_status_t         q_stat,
  output logic              push,
  output cmd_t              cmd
);

  logic slot_ok;

  // Compare one bit wider so that a full-range slot count still fits.
  assign slot_ok  = {1'b0, slot} < (SLOT_W + 1)'(SESSION_SLOTS);
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    cmd.slot   = slot;
    cmd.now    = now_sec;
    cmd.status = 1'b0;
    cmd.op     = OP_REPLY;
    case (kind)
      KIND_OPEN: begin
        if (slot_ok) begin
          cmd.op = OP_OPEN;
        end
      end
      KIND_TOUCH: begin
        if (slot_ok) begin
          cmd.op = OP_TOUCH;
        end else begin
          cmd.status = 1'b1;
        end
      end
      KIND_CHECK: begin
        cmd.op = OP_CHECK;
      end
      default: begin
        cmd.op = OP_REPLY;
      end
    endcase
  end

endmodule

@@ sv/isl_queue.sv @@
// ----------------------------------------------------------------------------
// isl_queue: short command queue
// Small first-in first-out buffer between classification and execution.
// ----------------------------------------------------------------------------
module isl_queue import isl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t q_stat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             entry [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign head         = entry[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/isl_back.sv @@
// ----------------------------------------------------------------------------
// isl_back: list execution
// Sequences the link and stamp memories, holds list ends, tracked bits,
// configuration and the result register.
// ----------------------------------------------------------------------------
module isl_back import isl_pkg::*; #(
  parameter int SESSION_SLOTS = DEF_SESSION_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  head,
  input  q_status_t             q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output res_t                  out_res
);

  localparam int IDX_W  = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] NONE = {1'b1, {IDX_W{1'b0}}};

  st_t                      state, state_next;
  cmd_t                     cur, cur_next;
  logic [LINK_W-1:0]        newest, newest_next;
  logic [LINK_W-1:0]        oldest, oldest_next;
  logic [SESSION_SLOTS-1:0] tracked, tracked_next;
  logic                     pend_valid, pend_valid_next;
  logic [IDX_W-1:0]         pend_slot, pend_slot_next;
  logic signed [32:0]       age, age_next;
  logic [TIMEOUT_W-1:0]     idle_timeout;
  logic [MARGIN_W-1:0]      expiry_margin;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              old_we, new_we, stamp_we;
  logic [IDX_W-1:0]  old_waddr, new_waddr;
  logic [LINK_W-1:0] old_wdata, new_wdata;
  logic [LINK_W-1:0] old_q, new_q;
  logic [TIME_W-1:0] stamp_q;

  logic              load;
  res_t              res;
  logic              out_free;
  logic [IDX_W-1:0]  hs, cur_s;
  logic              head_tracked;
  logic              n_valid, o_valid;
  logic signed [33:0] age_m, tmo_s, wait_full;
  logic              expire;
  logic [TIMEOUT_W-1:0] wait_sat;

  assign out_free     = !out_valid || !out_stall;
  assign hs           = head.slot[IDX_W-1:0];
  assign cur_s        = cur.slot[IDX_W-1:0];
  assign head_tracked = tracked[hs];
  assign n_valid      = !new_q[IDX_W];
  assign o_valid      = !old_q[IDX_W];

  // A slot expires once its age plus margin passes the timeout.
  assign tmo_s     = $signed({18'b0, idle_timeout});
  assign age_m     = $signed({age[32], age}) + $signed({26'b0, expiry_margin});
  assign expire    = age_m > tmo_s;
  assign wait_full = tmo_s - $signed({age[32], age});

  always_comb begin
    if (wait_full < 0) begin
      wait_sat = '0;
    end else if (wait_full > 34'sd65535) begin
      wait_sat = '1;
    end else begin
      wait_sat = wait_full[TIMEOUT_W-1:0];
    end
  end

  isl_ram #(.WIDTH(LINK_W), .DEPTH(SESSION_SLOTS)) u_older (
    .clk(clk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(old_q)
  );

  isl_ram #(.WIDTH(LINK_W), .DEPTH(SESSION_SLOTS)) u_newer (
    .clk(clk), .we(new_we), .waddr(new_waddr), .wdata(new_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(new_q)
  );

  isl_ram #(.WIDTH(TIME_W), .DEPTH(SESSION_SLOTS)) u_stamp (
    .clk(clk), .we(stamp_we), .waddr(cur_s), .wdata(cur.now),
    .re(rd_en), .raddr(rd_addr), .rdata(stamp_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          case (head.op)
            OP_OPEN, OP_TOUCH: begin
              if (head_tracked) begin
                state_next = ST_UL_WR;
              end else if (head.op == OP_TOUCH) begin
                state_next = ST_REPLY;
              end else begin
                state_next = ST_LK_SELF;
              end
            end
            OP_CHECK: state_next = ST_CK_RD;
            default:  state_next = ST_REPLY;
          endcase
        end
      end
      ST_UL_WR:   state_next = ST_LK_SELF;
      ST_LK_SELF: state_next = ST_LK_HEAD;
      ST_LK_HEAD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CK_RD: begin
        if (!oldest[IDX_W]) begin
          state_next = ST_CK_AGE;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CK_AGE: state_next = ST_CK_EVAL;
      ST_CK_EVAL: begin
        if (out_free) begin
          state_next = expire ? ST_CK_RD : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls, list updates and results.
  always_comb begin
    pop             = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = hs;
    old_we          = 1'b0;
    old_waddr       = cur_s;
    old_wdata       = NONE;
    new_we          = 1'b0;
    new_waddr       = cur_s;
    new_wdata       = NONE;
    stamp_we        = 1'b0;
    load            = 1'b0;
    res             = '0;
    cur_next        = cur;
    newest_next     = newest;
    oldest_next     = oldest;
    tracked_next    = tracked;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    age_next        = age;
    case (state)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          rd_en    = 1'b1;
          cur_next = head;
          if (head.op == OP_TOUCH && !head_tracked) begin
            cur_next.status = 1'b1;
          end
          if (head.op == OP_CHECK) begin
            pend_valid_next = 1'b0;
          end
        end
      end
      ST_UL_WR: begin
        // Bridge the slot's neighbors over it.
        if (n_valid) begin
          old_we    = 1'b1;
          old_waddr = new_q[IDX_W-1:0];
          old_wdata = old_q;
        end else begin
          newest_next = old_q;
        end
        if (o_valid) begin
          new_we    = 1'b1;
          new_waddr = old_q[IDX_W-1:0];
          new_wdata = new_q;
        end else begin
          oldest_next = new_q;
        end
      end
      ST_LK_SELF: begin
        old_we    = 1'b1;
        old_wdata = newest;
        new_we    = 1'b1;
        new_wdata = NONE;
        stamp_we  = 1'b1;
      end
      ST_LK_HEAD: begin
        if (out_free) begin
          if (!newest[IDX_W]) begin
            new_we    = 1'b1;
            new_waddr = newest[IDX_W-1:0];
            new_wdata = {1'b0, cur_s};
          end
          newest_next = {1'b0, cur_s};
          if (oldest[IDX_W]) begin
            oldest_next = {1'b0, cur_s};
          end
          tracked_next[cur_s] = 1'b1;
          load     = 1'b1;
          res.last = 1'b1;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          load       = 1'b1;
          res.status = cur.status;
          res.last   = 1'b1;
        end
      end
      ST_CK_RD: begin
        rd_addr = oldest[IDX_W-1:0];
        if (!oldest[IDX_W]) begin
          rd_en = 1'b1;
        end else if (out_free) begin
          // List ran empty: close out the check without a wait.
          load              = 1'b1;
          res.evicted_valid = pend_valid;
          res.evicted_slot  = pend_valid ? SLOT_W'(pend_slot) : '0;
          res.last          = 1'b1;
        end
      end
      ST_CK_AGE: begin
        age_next = $signed({1'b0, cur.now}) - $signed({1'b0, stamp_q});
      end
      ST_CK_EVAL: begin
        if (out_free) begin
          if (expire) begin
            // The previous eviction is now known not to be the final one.
            if (pend_valid) begin
              load              = 1'b1;
              res.evicted_valid = 1'b1;
              res.evicted_slot  = SLOT_W'(pend_slot);
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = oldest[IDX_W-1:0];
            tracked_next[oldest[IDX_W-1:0]] = 1'b0;
            if (n_valid) begin
              old_we    = 1'b1;
              old_waddr = new_q[IDX_W-1:0];
              old_wdata = NONE;
            end else begin
              newest_next = NONE;
            end
            oldest_next = new_q;
          end else begin
            load              = 1'b1;
            res.evicted_valid = pend_valid;
            res.evicted_slot  = pend_valid ? SLOT_W'(pend_slot) : '0;
            res.wait_valid    = 1'b1;
            res.wait_sec      = wait_sat;
            res.last          = 1'b1;
          end
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    pend_slot <= pend_slot_next;
    age       <= age_next;
    if (load) begin
      out_res <= res;
    end
    if (rst) begin
      state         <= ST_IDLE;
      newest        <= NONE;
      oldest        <= NONE;
      tracked       <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
      idle_timeout  <= RESET_IDLE_TIMEOUT;
      expiry_margin <= RESET_EXPIRY_MARGIN;
    end else begin
      state      <= state_next;
      newest     <= newest_next;
      oldest     <= oldest_next;
      tracked    <= tracked_next;
      pend_valid <= pend_valid_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_IDLE_TIMEOUT:  idle_timeout  <= cfg_data[TIMEOUT_W-1:0];
          CFG_EXPIRY_MARGIN: expiry_margin <= cfg_data[MARGIN_W-1:0];
          default:           idle_timeout  <= idle_timeout;
        endcase
      end
    end
  end

endmodule

@@ sv/idle_session_lru_timeout.sv @@
// ----------------------------------------------------------------------------
// idle_session_lru_timeout: idle session tracker with timeout eviction
// Keeps session slots in a list from most to least recently used and evicts
// slots that have stayed idle too long.
// ----------------------------------------------------------------------------
// Use: an input word carries kind (open, touch, check), slot and now_sec.
// It is accepted when in_valid is high and in_stall is low. Each word gives
// one or more result words on the output channel, taken when out_valid is
// high and out_stall is low; the final one of a word has last set.
// A short command queue sits between the input side and the list sequencer,
// so up to two words are taken while the sequencer is busy or a result
// waits for the receiver. The output register holds its word while
// out_stall is high and the sequencer then pauses.
// The sequencer is paced by the registered reads and the one write port of
// each link and stamp memory: an open or touch of a tracked slot steps
// through unlink writes, self link and head link; an open of a new slot
// through self link and head link; a rejected word through its reply. A
// check reads the stamp, ages and compares each slot it examines, with a
// closing step if the list runs empty; a result appears in the cycle after
// the sequencer's final step. Reset clears the queue, the list ends, the
// tracked bits and the output valid bit and loads idle_timeout 300 and
// expiry_margin 1. The link and stamp memories need no clearing, since only
// the contents of tracked slots are used. Configuration is written through
// cfg_write, cfg_index and cfg_data while the block is idle.
// ----------------------------------------------------------------------------
module idle_session_lru_timeout import isl_pkg::*; #(
  parameter int SESSION_SLOTS = DEF_SESSION_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            kind,
  input  logic [SLOT_W-1:0]     slot,
  input  logic [TIME_W-1:0]     now_sec,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  status,
  output logic                  evicted_valid,
  output logic [SLOT_W-1:0]     evicted_slot,
  output logic                  wait_valid,
  output logic [TIMEOUT_W-1:0]  wait_sec,
  output logic                  last
);

  q_status_t q_stat;
  cmd_t      push_cmd;
  cmd_t      head;
  logic      push;
  logic      pop;
  res_t      out_res;

  // Front: classify the word and push it into the queue.
  isl_front #(.SESSION_SLOTS(SESSION_SLOTS)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .slot     (slot),
    .now_sec  (now_sec),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  isl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: walk the list in the memories and build result words.
  isl_back #(.SESSION_SLOTS(SESSION_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign status        = out_res.status;
  assign evicted_valid = out_res.evicted_valid;
  assign evicted_slot  = out_res.evicted_slot;
  assign wait_valid    = out_res.wait_valid;
  assign wait_sec      = out_res.wait_sec;
  assign last          = out_res.last;

endmodule

@@ sv/isl_checker.sv @@
// ----------------------------------------------------------------------------
// isl_checker: port-level checks of the idle session tracker
// Result word consistency and output hold under stall.
// ----------------------------------------------------------------------------
module isl_checker import isl_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  status,
  input logic                  evicted_valid,
  input logic [SLOT_W-1:0]     evicted_slot,
  input logic                  wait_valid,
  input logic [TIMEOUT_W-1:0]  wait_sec,
  input logic                  last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(evicted_slot) && $stable(wait_sec)
      && $stable(last) && $stable(evicted_valid))
    else $error("result word changed while stalled");

  a_mid_is_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> evicted_valid && !wait_valid && !status)
    else $error("non-final result is not an eviction");

  a_wait_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && wait_valid |-> last && !status)
    else $error("wait reported outside a final check result");

  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last && !evicted_valid && !wait_valid)
    else $error("error status mixed with check fields");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_slot == '0)
    else $error("evicted slot set without an eviction");

endmodule

bind idle_session_lru_timeout isl_checker u_checker (.*);
